// ===== hw/rtl/s3x_pkg.sv =====
// ----------------------------------------------------------------------------
// s3x_pkg: shared types, constants and the Scale3x block rule
// Holds frame limits, the queue job format and the pixel comparison function
// used by the back end.
// ----------------------------------------------------------------------------
package s3x_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIX_W      = 24;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 10;
	localparam int DIM_W      = 11;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = QPTR_W + 1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [8:0]        block_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// per-word classification made by the front end
	typedef struct packed {
		logic             emit1;  // block for the previous column
		logic             emit2;  // block for the last column of the row
		logic             top;    // source row is the first row
		logic             bot;    // source row is the last row
		logic             l1;     // previous column is column zero
		logic             l2;     // current column is column zero
		logic [COL_W-1:0] col;    // current column
		logic [ROW_W-1:0] row;    // source row of the blocks
	} job_meta_t;

	typedef struct packed {
		block_t    win;   // 3x3 window, row-major, after the shift
		job_meta_t meta;
	} job_t;

	// Scale3x rule on neighbors A..J around E
	function automatic block_t scale_block(input pix_t a, input pix_t b, input pix_t c,
		input pix_t d, input pix_t e, input pix_t f, input pix_t g, input pix_t h,
		input pix_t j, input logic corner);
		block_t p;
		for (int i = 0; i < 9; i++) begin
			p[i] = e;
		end
		if (!corner && (b != h) && (d != f)) begin
			if (d == b) p[0] = d;
			if (((d == b) && (e != c)) || ((b == f) && (e != a))) p[1] = b;
			if (b == f) p[2] = f;
			if (((d == b) && (e != g)) || ((d == h) && (e != a))) p[3] = d;
			if (((b == f) && (e != j)) || ((h == f) && (e != c))) p[5] = f;
			if (d == h) p[6] = d;
			if (((d == h) && (e != j)) || ((h == f) && (e != g))) p[7] = h;
			if (h == f) p[8] = f;
		end
		return p;
	endfunction

endpackage

// ===== hw/rtl/s3x_front.sv =====
// ----------------------------------------------------------------------------
// s3x_front: pixel intake, line store and window
// Tracks the raster position, reads and rewrites the line store, shifts the
// 3x3 window and pushes one job per word that produces output blocks.
// ----------------------------------------------------------------------------
module s3x_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  s3x_pkg::pix_t               pixel_rgb,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [s3x_pkg::DIM_W-1:0]   cfg_wdata,
	input  logic [s3x_pkg::QCNT_W-1:0]  q_level,
	output logic                        push,
	output s3x_pkg::job_t               push_job
);

	localparam int DW = s3x_pkg::DIM_W;
	localparam int CW = s3x_pkg::QCNT_W + 1;

	logic [DW-1:0]                  width_q, height_q;
	logic [DW-1:0]                  w_eff, h_eff;
	logic [s3x_pkg::COL_W-1:0]      col_q, x_cur;
	logic [DW-1:0]                  row_q, y_cur, x_ext;
	logic                           at_end, accept;
	logic                           valid_s1, byp_s1;
	s3x_pkg::pix_t                  pix_s1;
	logic [s3x_pkg::ADDR_W-1:0]     addr_s1, x_addr;
	s3x_pkg::job_meta_t             meta_s1, meta_d;
	logic [2*s3x_pkg::PIX_W-1:0]    rd_s1, bypd_s1, fetched, wr_data;
	logic [2*s3x_pkg::PIX_W-1:0]    line_mem [s3x_pkg::MAX_WIDTH];
	s3x_pkg::block_t                window_q, win_next;

	// room check: the word in stage 1 and the new one must both fit
	assign in_ready = (CW'(q_level) + CW'(valid_s1)) < CW'(s3x_pkg::QDEPTH);
	assign accept   = in_valid && in_ready;

	// clamp the frame size registers
	always_comb begin
		w_eff = width_q;
		if (width_q == '0) w_eff = DW'(1);
		else if (width_q > DW'(s3x_pkg::MAX_WIDTH)) w_eff = DW'(s3x_pkg::MAX_WIDTH);
		h_eff = height_q;
		if (height_q == '0) h_eff = DW'(1);
		else if (height_q > DW'(s3x_pkg::MAX_HEIGHT)) h_eff = DW'(s3x_pkg::MAX_HEIGHT);
	end

	// current raster position and classification
	always_comb begin
		x_cur  = (DW'(col_q) >= w_eff) ? '0 : col_q;
		y_cur  = (row_q > h_eff) ? '0 : row_q;
		x_ext  = DW'(x_cur);
		at_end = (x_ext + DW'(1)) == w_eff;
		x_addr = x_cur[s3x_pkg::ADDR_W-1:0];
		meta_d.emit1 = (y_cur != '0) && (x_cur != '0);
		meta_d.emit2 = (y_cur != '0) && at_end;
		meta_d.top   = y_cur == DW'(1);
		meta_d.bot   = y_cur >= h_eff;
		meta_d.l1    = x_cur == s3x_pkg::COL_W'(1);
		meta_d.l2    = x_cur == '0;
		meta_d.col   = x_cur;
		meta_d.row   = s3x_pkg::ROW_W'(y_cur - DW'(1));
	end

	// configuration writes and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DW'(1);
			height_q <= DW'(1);
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (s3x_pkg::cfg_reg_t'(cfg_index))
					s3x_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata;
					s3x_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
			end
			valid_s1 <= accept;
			if (accept) begin
				if (at_end) begin
					col_q <= '0;
					row_q <= (y_cur >= h_eff) ? '0 : y_cur + DW'(1);
				end else begin
					col_q <= x_cur + s3x_pkg::COL_W'(1);
				end
			end
		end
	end

	// stage 1 payload and write-to-read bypass
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel_rgb;
			addr_s1 <= x_addr;
			meta_s1 <= meta_d;
			byp_s1  <= valid_s1 && (addr_s1 == x_addr);
			bypd_s1 <= wr_data;
		end
	end

	// line store: {row y-2, row y-1} per column
	always_ff @(posedge clk) begin
		if (valid_s1) line_mem[addr_s1] <= wr_data;
		if (accept) rd_s1 <= line_mem[x_addr];
	end

	assign fetched = byp_s1 ? bypd_s1 : rd_s1;
	assign wr_data = {fetched[s3x_pkg::PIX_W-1:0], pix_s1};

	// shift the window left and bring in the new column
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r*3]     = window_q[r*3+1];
			win_next[r*3 + 1] = window_q[r*3+2];
		end
		win_next[2] = fetched[2*s3x_pkg::PIX_W-1:s3x_pkg::PIX_W];
		win_next[5] = fetched[s3x_pkg::PIX_W-1:0];
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (valid_s1) begin
			window_q <= win_next;
		end
	end

	// push only words that produce blocks
	assign push          = valid_s1 && (meta_s1.emit1 || meta_s1.emit2);
	assign push_job.win  = win_next;
	assign push_job.meta = meta_s1;

endmodule

// ===== hw/rtl/s3x_queue.sv =====
// ----------------------------------------------------------------------------
// s3x_queue: job queue between front and back end
// A short first-in first-out queue of window jobs with an occupancy count.
// ----------------------------------------------------------------------------
module s3x_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  s3x_pkg::job_t               push_job,
	input  logic                        pop,
	output logic                        head_valid,
	output s3x_pkg::job_t               head_job,
	output logic [s3x_pkg::QCNT_W-1:0]  level
);

	s3x_pkg::job_t                 q_mem [s3x_pkg::QDEPTH];
	logic [s3x_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [s3x_pkg::QCNT_W-1:0]    count_q;

	assign head_valid = count_q != '0;
	assign head_job   = q_mem[rd_ptr_q];
	assign level      = count_q;

	// store entries
	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= push_job;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + s3x_pkg::QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + s3x_pkg::QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + s3x_pkg::QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - s3x_pkg::QCNT_W'(1);
		end
	end

endmodule

// ===== hw/rtl/s3x_back.sv =====
// ----------------------------------------------------------------------------
// s3x_back: block builder and output register
// Expands each queued job into one or two Scale3x blocks, one per cycle while
// out_ready does not stall the output, into a registered output word.
// ----------------------------------------------------------------------------
module s3x_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  s3x_pkg::job_t               head_job,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output s3x_pkg::block_t             out_blk,
	output logic [s3x_pkg::COL_W-1:0]   out_col,
	output logic [s3x_pkg::ROW_W-1:0]   out_row,
	output logic                        out_last
);

	logic                          phase_q, out_valid_q, sel2, load;
	logic [1:0]                    k, lc, rc, tr, br;
	logic                          corner;
	s3x_pkg::job_meta_t            meta;
	s3x_pkg::block_t               blk, blk_q;
	logic [s3x_pkg::COL_W-1:0]     col_q;
	logic [s3x_pkg::ROW_W-1:0]     row_q;
	logic                          last_q;

	function automatic s3x_pkg::pix_t pick(input s3x_pkg::block_t w, input logic [1:0] r,
		input logic [1:0] c);
		logic [3:0] idx;
		idx = 4'({2'b00, r} * 4'd3) + {2'b00, c};
		return w[idx];
	endfunction

	assign meta = head_job.meta;
	assign sel2 = phase_q || !meta.emit1;
	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && (sel2 || !meta.emit2);

	// select window columns and rows with edge clamping
	always_comb begin
		tr = meta.top ? 2'd1 : 2'd0;
		br = meta.bot ? 2'd1 : 2'd2;
		rc = 2'd2;
		if (sel2) begin
			k      = 2'd2;
			lc     = meta.l2 ? 2'd2 : 2'd1;
			corner = meta.top || meta.bot;
		end else begin
			k      = 2'd1;
			lc     = meta.l1 ? 2'd1 : 2'd0;
			corner = (meta.top || meta.bot) && meta.l1;
		end
		blk = s3x_pkg::scale_block(
			pick(head_job.win, tr, lc), pick(head_job.win, tr, k), pick(head_job.win, tr, rc),
			pick(head_job.win, 2'd1, lc), pick(head_job.win, 2'd1, k),
			pick(head_job.win, 2'd1, rc),
			pick(head_job.win, br, lc), pick(head_job.win, br, k), pick(head_job.win, br, rc),
			corner);
	end

	// output word control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= !pop;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load) begin
			blk_q  <= blk;
			row_q  <= meta.row;
			col_q  <= sel2 ? meta.col : meta.col - s3x_pkg::COL_W'(1);
			last_q <= sel2 || !meta.emit2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_blk   = blk_q;
	assign out_col   = col_q;
	assign out_row   = row_q;
	assign out_last  = last_q;

endmodule

// ===== hw/rtl/scale3x_pixel_upscaler.sv =====
// Path: an accepted word passes the stage 1 registers, the job queue and the output
// register before its first block shows.
// Throughput: one pixel word per cycle while in_ready is high, that is while the job queue
// has room; the row-end word emits two blocks, which both pass the single output register.
// Reset: clears position counters, window, queue and output valid; width and height
// return to 1. The line store is not cleared and holds nothing valid until a row is written.
// ----------------------------------------------------------------------------
// scale3x_pixel_upscaler: Scale3x 3x pixel-art upscaler
// Raster pixel words in, up to two 3x3 output blocks per word out, with front end,
// job queue and back end decoupled.
// ----------------------------------------------------------------------------
module scale3x_pixel_upscaler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [23:0]                 pixel_rgb,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [23:0]                 out_p0,
	output logic [23:0]                 out_p1,
	output logic [23:0]                 out_p2,
	output logic [23:0]                 out_p3,
	output logic [23:0]                 out_p4,
	output logic [23:0]                 out_p5,
	output logic [23:0]                 out_p6,
	output logic [23:0]                 out_p7,
	output logic [23:0]                 out_p8,
	output logic [9:0]                  src_col,
	output logic [9:0]                  src_row,
	output logic                        last_of_run,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [10:0]                 cfg_wdata
);

	logic                          push, pop, head_valid;
	s3x_pkg::job_t                 push_job, head_job;
	logic [s3x_pkg::QCNT_W-1:0]    q_level;
	s3x_pkg::block_t               out_blk;

	s3x_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_rgb (pixel_rgb),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_level   (q_level),
		.push      (push),
		.push_job  (push_job)
	);

	s3x_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.level      (q_level)
	);

	s3x_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_blk    (out_blk),
		.out_col    (src_col),
		.out_row    (src_row),
		.out_last   (last_of_run)
	);

	// unpack the block, top-left first
	assign out_p0 = out_blk[0];
	assign out_p1 = out_blk[1];
	assign out_p2 = out_blk[2];
	assign out_p3 = out_blk[3];
	assign out_p4 = out_blk[4];
	assign out_p5 = out_blk[5];
	assign out_p6 = out_blk[6];
	assign out_p7 = out_blk[7];
	assign out_p8 = out_blk[8];

endmodule

// ===== hw/rtl/s3x_checker.sv =====
// ----------------------------------------------------------------------------
// s3x_checker: port-level checks for the upscaler
// Watches the output channel for reset, stall and block consistency rules.
// ----------------------------------------------------------------------------
module s3x_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] out_p0,
	input  logic [23:0] out_p2,
	input  logic [23:0] out_p4,
	input  logic [23:0] out_p6,
	input  logic [23:0] out_p8,
	input  logic [9:0]  src_col,
	input  logic [9:0]  src_row,
	input  logic        last_of_run
);

	// no output word in the cycle after reset is seen held
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output word valid during reset");

	// a stalled output word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_p4) && $stable(src_col))
		else $error("stalled output word changed");

	// a non-final block is followed at once by the next column of the same row
	a_run_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=>
			out_valid && (src_col == $past(src_col) + 10'd1) && (src_row == $past(src_row)))
		else $error("second block of a row end missing or misplaced");

	// top and bottom corners of a block never both leave E on one side
	a_left_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_p0 != out_p4) |-> out_p6 == out_p4)
		else $error("top-left and bottom-left both differ from center");

	a_right_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_p2 != out_p4) |-> out_p8 == out_p4)
		else $error("top-right and bottom-right both differ from center");

endmodule

bind scale3x_pixel_upscaler s3x_checker u_s3x_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_p0      (out_p0),
	.out_p2      (out_p2),
	.out_p4      (out_p4),
	.out_p6      (out_p6),
	.out_p8      (out_p8),
	.src_col     (src_col),
	.src_row     (src_row),
	.last_of_run (last_of_run)
);
